[rtl/core/triangle_tangent_accumulator_core_assert.svh]
// Assertion macros for the tangent accumulator core.
`ifndef TRIANGLE_TANGENT_ACCUMULATOR_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TTA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m");
`define TTA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m");
`else
`define TTA_ASSERT(label, clk, rst_n, prop)
`define TTA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/core/tta_pkg.sv]
// Package with types and constants of the tangent accumulator core.
`timescale 1ns / 1ps
package tta_pkg;
  localparam int VertexCountDef = 1024;
  localparam int IdxW = 10;
  localparam int PosW = 32;
  localparam int UvW = 24;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_RD_A, ST_RD_B, ST_RD_C, ST_LAT_C, ST_DIFF, ST_MUL0, ST_MUL1,
    ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_MUL6, ST_DET, ST_NUM, ST_DIV_INIT, ST_DIV,
    ST_DIV_END, ST_ACC_RD, ST_ACC_WAIT, ST_ACC_WR, ST_READ_RD, ST_READ_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [IdxW-1:0] index_a;
    logic [IdxW-1:0] index_b;
    logic [IdxW-1:0] index_c;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [UvW-1:0] tex_u;
    logic signed [UvW-1:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] tan_x;
    logic signed [PosW-1:0] tan_y;
    logic signed [PosW-1:0] tan_z;
    logic degenerate;
  } out_item_t;

  localparam int VtxW = 3 * PosW + 2 * UvW;
  localparam int AccW = 3 * PosW;

  function automatic logic signed [PosW-1:0] sat_add(logic signed [PosW-1:0] a,
                                                    logic signed [PosW-1:0] b);
    logic signed [PosW:0] s;
    s = {a[PosW-1], a} + {b[PosW-1], b};
    if (s[PosW] != s[PosW-1]) sat_add = s[PosW] ? {1'b1, {(PosW-1){1'b0}}}
                                                : {1'b0, {(PosW-1){1'b1}}};
    else sat_add = s[PosW-1:0];
  endfunction
endpackage

[rtl/core/tta_if.sv]
// Valid/ready channel interfaces of the tangent accumulator core.
`timescale 1ns / 1ps
interface tta_in_if import tta_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tta_out_if import tta_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tta_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tta_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/core/triangle_tangent_accumulator_core.sv]
// Top level of the triangle tangent accumulator core.
//  channel | dir | payload
//  in_ch   | in  | kind, index_a/b/c, pos_x/y/z, tex_u/v
//  out_ch  | out | tan_x/y/z, degenerate
// One item is handled at a time. A triangle runs through three 31-step restoring
// dividers side by side (one quotient bit a cycle) and the one shared 33x33
// multiplier; a degenerate one skips the dividers. Memories need no clearing after reset.
// The result waits in an output register; no item is taken until it leaves,
// so a stalled output holds off the next item.
`timescale 1ns / 1ps
`include "triangle_tangent_accumulator_core_assert.svh"
module triangle_tangent_accumulator_core import tta_pkg::*; #(
  parameter int VertexCount = VertexCountDef
) (
  input logic clk_i,
  input logic rst_ni,
  tta_in_if.sink in_ch,
  tta_out_if.source out_ch
);
  localparam int AW = (VertexCount > 1) ? $clog2(VertexCount) : 1;
  localparam int DivSteps = 31;
  localparam int RemW = 52;
  localparam int QuoW = 31;

  state_e state_q, state_d;
  in_item_t item_q;
  logic [1:0] acc_lane_q;
  logic [4:0] div_cnt_q;

  logic vtx_we, acc_we;
  logic [AW-1:0] vtx_addr, acc_addr;
  logic [VtxW-1:0] vtx_wdata, vtx_rdata;
  logic [AccW-1:0] acc_wdata, acc_rdata;

  tta_ram #(.Width(VtxW), .Depth(VertexCount)) u_vtx_ram (
    .clk_i, .we_i(vtx_we), .addr_i(vtx_addr), .wdata_i(vtx_wdata), .rdata_o(vtx_rdata));
  tta_ram #(.Width(AccW), .Depth(VertexCount)) u_acc_ram (
    .clk_i, .we_i(acc_we), .addr_i(acc_addr), .wdata_i(acc_wdata), .rdata_o(acc_rdata));

  logic [VtxW-1:0] va_q, vb_q;
  logic signed [PosW:0] e_q [6];
  logic signed [UvW:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [65:0] prod_q;
  logic signed [66:0] det_q;
  logic signed [66:0] num_q [3];
  logic signed [PosW-1:0] tan_q [3];
  logic [RemW-1:0] dabs_q;
  logic [RemW-1:0] rem_q [3];
  logic [QuoW-1:0] low_q [3];
  logic [QuoW-1:0] quo_q [3];
  logic [2:0] neg_q, ovf_q;
  out_item_t out_q;
  logic out_valid_q;

  logic in_range;
  logic [IdxW-1:0] idx_sel;
  always_comb begin
    in_range = 1'b1;
    if (32'(in_ch.data.index_a) >= VertexCount) in_range = 1'b0;
    if (in_ch.data.kind == KIND_TRI && (32'(in_ch.data.index_b) >= VertexCount ||
        32'(in_ch.data.index_c) >= VertexCount)) in_range = 1'b0;
  end

  assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // multiplier operands per step
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL0: begin mul_a = 33'(du1_q); mul_b = 33'(dv2_q); end
      ST_MUL1: begin mul_a = 33'(du2_q); mul_b = 33'(dv1_q); end
      ST_MUL2: begin mul_a = e_q[0]; mul_b = 33'(dv2_q); end
      ST_MUL3: begin mul_a = e_q[3]; mul_b = 33'(dv1_q); end
      ST_MUL4: begin mul_a = e_q[1]; mul_b = 33'(dv2_q); end
      ST_MUL5: begin mul_a = e_q[4]; mul_b = 33'(dv1_q); end
      ST_MUL6: begin mul_a = e_q[2]; mul_b = 33'(dv2_q); end
      ST_DET:  begin mul_a = e_q[5]; mul_b = 33'(dv1_q); end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && in_range) begin
        case (kind_e'(in_ch.data.kind))
          KIND_LOAD: state_d = ST_LOAD;
          KIND_TRI:  state_d = ST_RD_A;
          KIND_READ: state_d = ST_READ_RD;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: state_d = ST_RD_C;
      ST_RD_C: state_d = ST_LAT_C;
      ST_LAT_C: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_MUL5;
      ST_MUL5: state_d = ST_MUL6;
      ST_MUL6: state_d = ST_DET;
      ST_DET: state_d = ST_NUM;
      ST_NUM: state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = (det_q == '0) ? ST_OUT : ST_DIV;
      ST_DIV: if (div_cnt_q == 5'(DivSteps - 1)) state_d = ST_DIV_END;
      ST_DIV_END: state_d = ST_ACC_RD;
      ST_ACC_RD: state_d = ST_ACC_WAIT;
      ST_ACC_WAIT: state_d = ST_ACC_WR;
      ST_ACC_WR: state_d = (acc_lane_q == 2'd2) ? ST_OUT : ST_ACC_RD;
      ST_READ_RD: state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic [IdxW-1:0] acc_idx;
  always_comb begin
    case (acc_lane_q)
      2'd0: acc_idx = item_q.index_a;
      2'd1: acc_idx = item_q.index_b;
      default: acc_idx = item_q.index_c;
    endcase
    idx_sel = item_q.index_a;
    if (state_q == ST_RD_B) idx_sel = item_q.index_b;
    if (state_q == ST_RD_C) idx_sel = item_q.index_c;
  end

  always_comb begin
    vtx_we = (state_q == ST_LOAD);
    vtx_addr = AW'(idx_sel);
    vtx_wdata = {item_q.pos_x, item_q.pos_y, item_q.pos_z, item_q.tex_u, item_q.tex_v};
    acc_we = (state_q == ST_LOAD) || (state_q == ST_ACC_WR);
    acc_addr = (state_q == ST_LOAD || state_q == ST_READ_RD) ? AW'(item_q.index_a)
                                                           : AW'(acc_idx);
    if (state_q == ST_LOAD) acc_wdata = '0;
    else acc_wdata = {sat_add(acc_rdata[95:64], tan_q[0]),
                      sat_add(acc_rdata[63:32], tan_q[1]),
                      sat_add(acc_rdata[31:0], tan_q[2])};
  end

  // divide |num| << 16 by |det|, one quotient bit per lane a cycle
  logic [66:0] dabs_c;
  logic [66:0] nabs_c [3];
  logic [RemW-1:0] rem_sh [3];
  logic [RemW:0] trial [3];
  logic signed [PosW-1:0] tan_c [3];
  always_comb begin
    dabs_c = det_q[66] ? -det_q : det_q;
    for (int l = 0; l < 3; l++) begin
      nabs_c[l] = num_q[l][66] ? -num_q[l] : num_q[l];
      rem_sh[l] = {rem_q[l][RemW-2:0], low_q[l][QuoW-1]};
      trial[l] = {1'b0, rem_sh[l]} - {1'b0, dabs_q};
      if (ovf_q[l]) tan_c[l] = neg_q[l] ? {1'b1, {(PosW-1){1'b0}}}
                                        : {1'b0, {(PosW-1){1'b1}}};
      else if (neg_q[l]) tan_c[l] = -{1'b0, quo_q[l]};
      else tan_c[l] = {1'b0, quo_q[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_lane_q <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
      if (state_q == ST_DIV_INIT) div_cnt_q <= '0;
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 5'd1;
      if (state_q == ST_DIV_INIT) acc_lane_q <= '0;
      else if (state_q == ST_ACC_WR) acc_lane_q <= acc_lane_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_ch.data;
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_RD_B: va_q <= vtx_rdata;
      ST_RD_C: vb_q <= vtx_rdata;
      ST_LAT_C: begin
        e_q[0] <= 33'(signed'(vb_q[143:112])) - 33'(signed'(va_q[143:112]));
        e_q[1] <= 33'(signed'(vb_q[111:80])) - 33'(signed'(va_q[111:80]));
        e_q[2] <= 33'(signed'(vb_q[79:48])) - 33'(signed'(va_q[79:48]));
        e_q[3] <= 33'(signed'(vtx_rdata[143:112])) - 33'(signed'(va_q[143:112]));
        e_q[4] <= 33'(signed'(vtx_rdata[111:80])) - 33'(signed'(va_q[111:80]));
        e_q[5] <= 33'(signed'(vtx_rdata[79:48])) - 33'(signed'(va_q[79:48]));
        du1_q <= 25'(signed'(vb_q[47:24])) - 25'(signed'(va_q[47:24]));
        dv1_q <= 25'(signed'(vb_q[23:0])) - 25'(signed'(va_q[23:0]));
        du2_q <= 25'(signed'(vtx_rdata[47:24])) - 25'(signed'(va_q[47:24]));
        dv2_q <= 25'(signed'(vtx_rdata[23:0])) - 25'(signed'(va_q[23:0]));
      end
      ST_MUL1: det_q <= 67'(prod_q);
      ST_MUL2: det_q <= det_q - 67'(prod_q);
      ST_MUL3: num_q[0] <= 67'(prod_q);
      ST_MUL4: num_q[0] <= num_q[0] - 67'(prod_q);
      ST_MUL5: num_q[1] <= 67'(prod_q);
      ST_MUL6: num_q[1] <= num_q[1] - 67'(prod_q);
      ST_DET: num_q[2] <= 67'(prod_q);
      ST_NUM: num_q[2] <= num_q[2] - 67'(prod_q);
      ST_DIV_INIT: begin
        dabs_q <= dabs_c[RemW-1:0];
        for (int l = 0; l < 3; l++) begin
          rem_q[l] <= nabs_c[l][66:15];
          low_q[l] <= {nabs_c[l][14:0], 16'b0};
          quo_q[l] <= '0;
          neg_q[l] <= num_q[l][66] != det_q[66];
          ovf_q[l] <= nabs_c[l] >= {dabs_c[51:0], 15'b0};
        end
        if (det_q == '0)
          out_q <= '{tan_x: '0, tan_y: '0, tan_z: '0, degenerate: 1'b1};
      end
      ST_DIV: begin
        for (int l = 0; l < 3; l++) begin
          low_q[l] <= {low_q[l][QuoW-2:0], 1'b0};
          if (!trial[l][RemW]) begin
            rem_q[l] <= trial[l][RemW-1:0];
            quo_q[l] <= {quo_q[l][QuoW-2:0], 1'b1};
          end else begin
            rem_q[l] <= rem_sh[l];
            quo_q[l] <= {quo_q[l][QuoW-2:0], 1'b0};
          end
        end
      end
      ST_DIV_END: begin
        for (int l = 0; l < 3; l++) tan_q[l] <= tan_c[l];
        out_q <= '{tan_x: tan_c[0], tan_y: tan_c[1], tan_z: tan_c[2], degenerate: 1'b0};
      end
      ST_READ_WAIT:
        out_q <= '{tan_x: acc_rdata[95:64], tan_y: acc_rdata[63:32],
                   tan_z: acc_rdata[31:0], degenerate: 1'b0};
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data = out_q;

  `TTA_ASSERT(a_out_hold, clk_i, rst_ni, out_ch.valid && !out_ch.ready |=> out_ch.valid)
  `TTA_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, in_fire && state_q != ST_IDLE)
  `TTA_ASSERT_NEVER(a_single_we, clk_i, rst_ni, acc_we && vtx_we && state_q != ST_LOAD)
endmodule

[dv/triangle_tangent_accumulator_core_tb.sv]
// Self-checking testbench for the triangle tangent accumulator core.
`timescale 1ns / 1ps
module triangle_tangent_accumulator_core_tb;
  import tta_pkg::*;

  class tangent_scoreboard;
    logic signed [PosW-1:0] px[VertexCountDef];
    logic signed [PosW-1:0] py[VertexCountDef];
    logic signed [PosW-1:0] pz[VertexCountDef];
    logic signed [UvW-1:0] tu[VertexCountDef];
    logic signed [UvW-1:0] tv[VertexCountDef];
    logic signed [PosW-1:0] ax[VertexCountDef];
    logic signed [PosW-1:0] ay[VertexCountDef];
    logic signed [PosW-1:0] az[VertexCountDef];
    out_item_t pending_tangents[$];
    int errors = 0;

    function automatic logic signed [31:0] clamp_q16(longint v);
      if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -longint'(64'sd2147483648)) return 32'sh80000000;
      return v[31:0];
    endfunction

    function automatic logic signed [31:0] quotient_q16(longint num, longint den);
      bit neg;
      longint unsigned n, d, ip, r, q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      ip = n / d;
      r = n % d;
      if (ip >= 64'd65536) return neg ? 32'sh80000000 : 32'sh7fffffff;
      q = ip;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      if (neg) return (q >= 64'h8000_0000) ? 32'sh80000000 : 32'(-longint'(q));
      return (q > 64'h7fff_ffff) ? 32'sh7fffffff : 32'(q);
    endfunction

    function automatic void add_tangent(int k, out_item_t t);
      ax[k] = clamp_q16(longint'(ax[k]) + longint'(t.tan_x));
      ay[k] = clamp_q16(longint'(ay[k]) + longint'(t.tan_y));
      az[k] = clamp_q16(longint'(az[k]) + longint'(t.tan_z));
    endfunction

    function automatic void note_input(in_item_t it);
      out_item_t res;
      int a, b, c;
      longint e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2, det;
      a = it.index_a;
      b = it.index_b;
      c = it.index_c;
      res = '0;
      case (kind_e'(it.kind))
        KIND_LOAD: begin
          px[a] = it.pos_x;
          py[a] = it.pos_y;
          pz[a] = it.pos_z;
          tu[a] = it.tex_u;
          tv[a] = it.tex_v;
          ax[a] = '0;
          ay[a] = '0;
          az[a] = '0;
        end
        KIND_READ: begin
          res.tan_x = ax[a];
          res.tan_y = ay[a];
          res.tan_z = az[a];
          pending_tangents = {pending_tangents, res};
        end
        KIND_TRI: begin
          e1x = longint'(px[b]) - px[a];
          e1y = longint'(py[b]) - py[a];
          e1z = longint'(pz[b]) - pz[a];
          e2x = longint'(px[c]) - px[a];
          e2y = longint'(py[c]) - py[a];
          e2z = longint'(pz[c]) - pz[a];
          du1 = longint'(tu[b]) - tu[a];
          dv1 = longint'(tv[b]) - tv[a];
          du2 = longint'(tu[c]) - tu[a];
          dv2 = longint'(tv[c]) - tv[a];
          det = du1 * dv2 - du2 * dv1;
          if (det == 0) begin
            res.degenerate = 1'b1;
          end else begin
            res.tan_x = quotient_q16(e1x * dv2 - e2x * dv1, det);
            res.tan_y = quotient_q16(e1y * dv2 - e2y * dv1, det);
            res.tan_z = quotient_q16(e1z * dv2 - e2z * dv1, det);
            add_tangent(a, res);
            add_tangent(b, res);
            add_tangent(c, res);
          end
          pending_tangents = {pending_tangents, res};
        end
        default: ;
      endcase
    endfunction

    function automatic void check_result(out_item_t got);
      out_item_t exp;
      if (pending_tangents.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp = pending_tangents.pop_front();
      if (got.tan_x !== exp.tan_x) begin
        $error("tan_x expected %h actual %h", exp.tan_x, got.tan_x);
        errors++;
      end
      if (got.tan_y !== exp.tan_y) begin
        $error("tan_y expected %h actual %h", exp.tan_y, got.tan_y);
        errors++;
      end
      if (got.tan_z !== exp.tan_z) begin
        $error("tan_z expected %h actual %h", exp.tan_z, got.tan_z);
        errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $error("degenerate expected %b actual %b", exp.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  tta_in_if in_ch ();
  tta_out_if out_ch ();

  triangle_tangent_accumulator_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  tangent_scoreboard tangents = new();
  int tx_idle_pct = 19;
  int rx_idle_pct = 87;
  bit loaded[VertexCountDef];
  int loaded_list[$];
  int vertex_pool[$];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) tangents.check_result(out_ch.data);
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    tangents.note_input(it);
    if (it.kind == KIND_LOAD && !loaded[it.index_a]) begin
      loaded[it.index_a] = 1'b1;
      loaded_list = {loaded_list, int'(it.index_a)};
    end
    @(negedge clk_i);
  endtask

  function automatic in_item_t noise_item(kind_e k);
    in_item_t it;
    it.kind = k;
    it.index_a = IdxW'($urandom);
    it.index_b = IdxW'($urandom);
    it.index_c = IdxW'($urandom);
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.tex_u = UvW'($urandom);
    it.tex_v = UvW'($urandom);
    return it;
  endfunction

  task automatic load_vertex(int idx, int x, int y, int z, int u, int v);
    in_item_t it;
    it = noise_item(KIND_LOAD);
    it.index_a = IdxW'(idx);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.tex_u = UvW'(u);
    it.tex_v = UvW'(v);
    send_item(it);
  endtask

  task automatic send_triangle(int a, int b, int c);
    in_item_t it;
    it = noise_item(KIND_TRI);
    it.index_a = IdxW'(a);
    it.index_b = IdxW'(b);
    it.index_c = IdxW'(c);
    send_item(it);
  endtask

  task automatic send_read(int a);
    in_item_t it;
    it = noise_item(KIND_READ);
    it.index_a = IdxW'(a);
    send_item(it);
  endtask

  function automatic int rand_pos();
    if ($urandom_range(4) == 0) return $urandom;
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic int rand_uv();
    int r;
    r = $urandom;
    if ($urandom_range(4) == 0) return $signed(r[23:0]);
    if ($urandom_range(9) == 0) return 0;
    return $signed($urandom_range(16'h4000)) - 16'sh2000;
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  task automatic random_item();
    int sel;
    int k;
    sel = $urandom_range(99);
    if (sel < 30) begin
      load_vertex(vertex_pool[$urandom_range(vertex_pool.size() - 1)],
                  rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
    end else if (sel < 75) begin
      k = pick_loaded();
      if ($urandom_range(19) == 0) send_triangle(k, k, pick_loaded());
      else send_triangle(k, pick_loaded(), pick_loaded());
    end else if (sel < 95) begin
      send_read(pick_loaded());
    end else begin
      send_item(noise_item(KIND_NONE));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_vertex(0, 0, 0, 0, 0, 0);
    load_vertex(1, 32'sh0001_0000, 0, 0, 24'sh01_0000, 0);
    load_vertex(2, 0, 32'sh0001_0000, 0, 0, 24'sh01_0000);
    send_triangle(0, 1, 2);
    send_read(0);
    send_triangle(0, 0, 1);
    send_triangle(2, 2, 2);
    load_vertex(1023, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                24'sh7f_ffff, 24'sh80_0000);
    load_vertex(3, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 24'sh7f_ffff, 24'sh7f_ffff);
    load_vertex(4, 32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003,
                24'sh80_0000, 24'sh7f_ffff);
    send_triangle(1023, 3, 4);
    load_vertex(5, 32'sh7fff_0000, 32'sh8001_0000, 32'sh7fff_0000, 24'sh00_0001, 0);
    load_vertex(6, 32'sh8000_0000, 32'sh7fff_0000, 32'sh8000_0000, 0, 24'sh00_0001);
    send_triangle(0, 5, 6);
    send_triangle(0, 5, 6);
    send_triangle(0, 5, 6);
    send_read(5);
    send_read(6);
    send_item(noise_item(KIND_NONE));
    send_read(1023);
    send_triangle(1023, 0, 1);
    load_vertex(0, 32'sh1234_5678, 32'shedcb_a987, 32'sh0f0f_0f0f, 24'sh12_3456, 24'she0_0001);
    send_read(0);

    vertex_pool = '{0, 1, 2, 3, 4, 5, 6, 1023};
    repeat (20) vertex_pool = {vertex_pool, int'($urandom_range(VertexCountDef - 1))};
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 87 : 0;
      rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 19 : 0;
      repeat (360) random_item();
    end
    in_ch.valid <= 1'b0;

    while (tangents.pending_tangents.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (tangents.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
